// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file hee_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, ignored while reset is asserted
`define HEE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// same, with a message of the caller
`define HEE_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`endif

// ===== sv/hee_pkg.sv =====
// shared types, character codes and the latin-1 entity name table
// no dependencies
`default_nettype none

package hee_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int POS_W       = 4;  // up to nine characters per input byte

	localparam logic [1:0] MODE_ALL  = 2'd0;
	localparam logic [1:0] MODE_RAW  = 2'd1;
	localparam logic [1:0] MODE_HIGH = 2'd2;

	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QUOT   = 8'h22;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] ENT_BASE  = 8'd160;

	typedef enum logic [1:0] {
		BODY_NONE,
		BODY_CHAR,
		BODY_ENT
	} body_kind_t;

	// one classified input byte; name is right-justified, first char highest
	typedef struct packed {
		logic       emit_held;
		logic       held_gt;
		body_kind_t kind;
		logic [7:0] ch;
		logic [47:0] name;
		logic [2:0] nlen;
	} esc_desc_t;

	localparam logic [47:0] NAME_AMP  = 48'("amp");
	localparam logic [47:0] NAME_LT   = 48'("lt");
	localparam logic [47:0] NAME_GT   = 48'("gt");
	localparam logic [47:0] NAME_QUOT = 48'("quot");

	localparam logic [47:0] ENT_NAME [0:95] = '{
		48'("nbsp"), 48'("iexcl"), 48'("cent"), 48'("pound"), 48'("curren"),
		48'("yen"), 48'("brvbar"), 48'("sect"), 48'("uml"), 48'("copy"),
		48'("ordf"), 48'("laquo"), 48'("not"), 48'("shy"), 48'("reg"),
		48'("macr"), 48'("deg"), 48'("plusmn"), 48'("sup2"), 48'("sup3"),
		48'("acute"), 48'("micro"), 48'("para"), 48'("middot"), 48'("cedil"),
		48'("sup1"), 48'("ordm"), 48'("raquo"), 48'("frac14"), 48'("frac12"),
		48'("frac34"), 48'("iquest"), 48'("Agrave"), 48'("Aacute"), 48'("Acirc"),
		48'("Atilde"), 48'("Auml"), 48'("Aring"), 48'("AElig"), 48'("Ccedil"),
		48'("Egrave"), 48'("Eacute"), 48'("Ecirc"), 48'("Euml"), 48'("Igrave"),
		48'("Iacute"), 48'("Icirc"), 48'("Iuml"), 48'("ETH"), 48'("Ntilde"),
		48'("Ograve"), 48'("Oacute"), 48'("Ocirc"), 48'("Otilde"), 48'("Ouml"),
		48'("times"), 48'("Oslash"), 48'("Ugrave"), 48'("Uacute"), 48'("Ucirc"),
		48'("Uuml"), 48'("Yacute"), 48'("THORN"), 48'("szlig"), 48'("agrave"),
		48'("aacute"), 48'("acirc"), 48'("atilde"), 48'("auml"), 48'("aring"),
		48'("aelig"), 48'("ccedil"), 48'("egrave"), 48'("eacute"), 48'("ecirc"),
		48'("euml"), 48'("igrave"), 48'("iacute"), 48'("icirc"), 48'("iuml"),
		48'("eth"), 48'("ntilde"), 48'("ograve"), 48'("oacute"), 48'("ocirc"),
		48'("otilde"), 48'("ouml"), 48'("divide"), 48'("oslash"), 48'("ugrave"),
		48'("uacute"), 48'("ucirc"), 48'("uuml"), 48'("yacute"), 48'("thorn"),
		48'("yuml")
	};

	// number of characters in a right-justified name
	function automatic logic [2:0] name_len(input logic [47:0] name);
		logic [2:0] len;
		len = 3'd0;
		for (int k = 0; k < 6; k++) begin
			if (name[k*8 +: 8] != 8'h00) len = 3'(k + 1);
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== sv/html_entity_escaper.sv =====
// HTML entity escaper with Latin-1 named entities, top level
// depends on hee_pkg, hee_front, hee_queue, hee_back
//
// Input stream s_*: one text byte per transfer, s_tlast on the last byte of
// a string. Output stream m_*: one character per transfer, m_tlast on the
// last character caused by an input byte. A byte gives zero to nine chars.
// cfg_we/cfg_wdata write the escape mode (0 all, 1 raw [< >] regions,
// 2 high bytes only); write it only while the block is idle.
// The first character of a byte reaches m_* through the descriptor queue
// and then the output register. Throughput: one output character per cycle
// while m_tready is high; a byte that expands to n characters holds the back
// end until all n are out, so plain text flows at one byte per cycle. The
// front end takes a byte every cycle until the four-entry descriptor queue
// is full, so s_tready drops while long entities drain. A stalled receiver
// holds the output register and the queue fills behind it; nothing is lost.
// Reset clears the mode to 0, the raw-region flag, the held bracket, the
// queue and the output valid flag.
`default_nettype none

module html_entity_escaper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata,   // escape_mode
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,     // [7:0] text_byte
	input  wire logic       s_tlast,     // end_of_text
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,     // [7:0] out_char
	output logic            m_tlast      // last_of_run
);

	logic               q_full;
	logic               in_fire;
	logic               push;
	logic               pop;
	logic               head_valid;
	hee_pkg::esc_desc_t push_desc;
	hee_pkg::esc_desc_t head_desc;

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	hee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.desc      (push_desc)
	);

	hee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	hee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/hee_front.sv =====
// front end: takes input bytes, tracks raw regions and the held bracket,
// and classifies each byte into a descriptor; uses hee_pkg
`default_nettype none

module hee_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_wdata,
	input  wire logic             in_fire,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_last,
	output logic                  push,
	output hee_pkg::esc_desc_t    desc
);

	logic [1:0] mode_q;
	logic       inside_q;
	logic       held_q;

	logic       raw_mode;
	logic       full;
	logic       consumed;
	logic       hold_new;
	logic       body_full;
	logic       has_body;
	logic       inside_nxt;
	logic [6:0] ent_off;
	logic [47:0] name;

	always_comb begin
		raw_mode = (mode_q == hee_pkg::MODE_RAW);
		full     = (mode_q != hee_pkg::MODE_HIGH);
		consumed = held_q && raw_mode &&
			((!inside_q && in_byte == hee_pkg::CH_LT) ||
			 (inside_q && in_byte == hee_pkg::CH_RBRACK));
		hold_new   = 1'b0;
		has_body   = 1'b0;
		body_full  = full;
		inside_nxt = inside_q;
		if (consumed) begin
			inside_nxt = !inside_q;
		end else if (!raw_mode) begin
			inside_nxt = 1'b0;
			has_body   = 1'b1;
		end else if (!inside_q) begin
			if (in_byte == hee_pkg::CH_LBRACK && !in_last) hold_new = 1'b1;
			else has_body = 1'b1;
			body_full = 1'b1;
		end else begin
			if (in_byte == hee_pkg::CH_GT && !in_last) hold_new = 1'b1;
			else has_body = 1'b1;
			body_full = 1'b0;
		end
	end

	// body classification
	always_comb begin
		ent_off = 7'(in_byte - hee_pkg::ENT_BASE);
		name    = '0;
		if (in_byte >= hee_pkg::ENT_BASE) begin
			name = hee_pkg::ENT_NAME[ent_off];
		end else if (body_full) begin
			case (in_byte)
				hee_pkg::CH_AMP:  name = hee_pkg::NAME_AMP;
				hee_pkg::CH_LT:   name = hee_pkg::NAME_LT;
				hee_pkg::CH_GT:   name = hee_pkg::NAME_GT;
				hee_pkg::CH_QUOT: name = hee_pkg::NAME_QUOT;
				default:          name = '0;
			endcase
		end
		desc.emit_held = held_q && !consumed;
		desc.held_gt   = inside_q;
		desc.ch        = in_byte;
		desc.name      = name;
		desc.nlen      = hee_pkg::name_len(name);
		if (!has_body) desc.kind = hee_pkg::BODY_NONE;
		else if (name != '0) desc.kind = hee_pkg::BODY_ENT;
		else desc.kind = hee_pkg::BODY_CHAR;
		push = in_fire && (desc.emit_held || has_body);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= hee_pkg::MODE_ALL;
			inside_q <= 1'b0;
			held_q   <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (in_fire) begin
				// end of string clears all region state
				inside_q <= inside_nxt && !in_last;
				held_q   <= hold_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/hee_queue.sv =====
// short descriptor queue between front and back end
// uses hee_pkg
`default_nettype none

module hee_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hee_pkg::esc_desc_t push_desc,
	input  wire logic             pop,
	output logic                  full,
	output logic                  head_valid,
	output hee_pkg::esc_desc_t    head_desc
);

	hee_pkg::esc_desc_t mem_q [hee_pkg::QUEUE_DEPTH];

	logic [hee_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [hee_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [hee_pkg::QUEUE_AW:0]   count_q;

	assign full       = (count_q == (hee_pkg::QUEUE_AW + 1)'(hee_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/hee_back.sv =====
// back end: expands one descriptor into output characters, one per cycle
// while the output is not stalled, into the output register; uses hee_pkg
`default_nettype none

module hee_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire hee_pkg::esc_desc_t head_desc,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);

	logic                     busy_q;
	hee_pkg::esc_desc_t       desc_q;
	logic [hee_pkg::POS_W-1:0] pos_q;
	logic                     valid_q;
	logic [7:0]               data_q;
	logic                     last_q;

	hee_pkg::esc_desc_t       cur;
	logic                     cur_valid;
	logic [hee_pkg::POS_W-1:0] cur_pos;
	logic [hee_pkg::POS_W-1:0] body_len;
	logic [hee_pkg::POS_W-1:0] total_len;
	logic [hee_pkg::POS_W-1:0] bpos;
	logic [2:0]               byte_sel;
	logic [7:0]               ch;
	logic                     is_last;
	logic                     advance;
	logic                     fire;

	always_comb begin
		cur       = busy_q ? desc_q : head_desc;
		cur_valid = busy_q || head_valid;
		cur_pos   = busy_q ? pos_q : '0;
		case (cur.kind)
			hee_pkg::BODY_CHAR: body_len = 4'd1;
			hee_pkg::BODY_ENT:  body_len = {1'b0, cur.nlen} + 4'd2;
			default:            body_len = '0;
		endcase
		total_len = body_len + {3'b0, cur.emit_held};
		bpos      = cur_pos - {3'b0, cur.emit_held};
		// name chars sit right-justified, first char in the highest byte
		byte_sel  = cur.nlen - bpos[2:0];
		ch        = 8'h00;
		if (cur.emit_held && cur_pos == '0) begin
			ch = cur.held_gt ? hee_pkg::CH_GT : hee_pkg::CH_LBRACK;
		end else begin
			case (cur.kind)
				hee_pkg::BODY_CHAR: ch = cur.ch;
				hee_pkg::BODY_ENT: begin
					if (bpos == '0) ch = hee_pkg::CH_AMP;
					else if (bpos == {1'b0, cur.nlen} + 4'd1) ch = hee_pkg::CH_SEMI;
					else begin
						for (int k = 0; k < 6; k++) begin
							if (byte_sel == 3'(k)) ch = cur.name[k*8 +: 8];
						end
					end
				end
				default: ch = 8'h00;
			endcase
		end
		is_last = (cur_pos == total_len - 4'd1);
		advance = !valid_q || m_tready;
		fire    = advance && cur_valid;
		pop     = fire && !busy_q;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= ch;
			last_q <= is_last;
			desc_q <= cur;
			pos_q  <= cur_pos + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (advance) valid_q <= cur_valid;
			if (fire) busy_q <= !is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== sv/hee_checker.sv =====
// port-level checks for html_entity_escaper, attached by bind
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hee_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// stalled output holds
	`HEE_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// an expansion in progress continues without gaps
	`HEE_ASSERT(a_run_contiguous, clk, arst_n, m_tvalid && m_tready && !m_tlast |=> m_tvalid)
	// a full queue implies the output register is loaded
	`HEE_ASSERT(a_backpressure, clk, arst_n, !s_tready |-> m_tvalid)
	// a semicolon only ever closes a run
	`HEE_ASSERT_MSG(a_semi_last, clk, arst_n, m_tvalid && m_tdata == 8'h3B |-> m_tlast, "semicolon not last of run")

endmodule

bind html_entity_escaper hee_checker u_hee_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
